/* src/vsc_pkg.sv */
`timescale 1ns / 1ps

package vsc_pkg;

    // Key storage
    localparam int KEY_CHARS  = 32;
    localparam int KEY_POS_W  = 5;
    localparam int KEY_LEN_W  = 6;
    localparam int KEY_WORDS  = 4;
    localparam int WORD_W     = 64;

    // Character and modulus constants
    localparam int CH_W       = 7;
    localparam int OUT_W      = 8;
    localparam int ARITH_W    = 10;
    localparam int ALPHA_LEN  = 26;
    localparam int BASE_UPPER = 65;
    localparam int BASE_LOWER = 97;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_CASE_MODE = 3'd0,
        REG_DIRECTION = 3'd1,
        REG_KEY_LEN   = 3'd2,
        REG_KEY_WORD0 = 3'd3,
        REG_KEY_WORD1 = 3'd4,
        REG_KEY_WORD2 = 3'd5,
        REG_KEY_WORD3 = 3'd6
    } t_reg_idx;

    // Case modes
    typedef enum logic [1:0] {
        MODE_UPPER = 2'd0,
        MODE_LOWER = 2'd1,
        MODE_MIXED = 2'd2,
        MODE_MIXED_ALT = 2'd3
    } t_case_mode;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_KEY    = 2'd1,
        ST_TEXT_CASE = 2'd2,
        ST_KEY_CASE  = 2'd3
    } t_status;

    localparam logic DIR_ENCRYPT = 1'b0;

    // Live configuration seen by the transform
    typedef struct packed {
        t_case_mode                           case_mode;
        logic                                 direction;
        logic [KEY_LEN_W-1:0]                 key_length;
        logic [KEY_WORDS-1:0][WORD_W-1:0]     key_word;
    } t_cfg;

    // Transform result for one character
    typedef struct packed {
        logic [OUT_W-1:0]     out_ch;
        t_status              status;
        logic [KEY_POS_W-1:0] next_pos;
    } t_xform_res;

endpackage

/* src/vsc_if.sv */
`timescale 1ns / 1ps

// Character request channel
interface vsc_in_if;
    logic       valid;
    logic       ready;
    logic [6:0] ch;
    logic       first;

    modport source (output valid, output ch, output first, input ready);
    modport sink   (input valid, input ch, input first, output ready);
endinterface

// Result request channel
interface vsc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_ch;
    logic [1:0] status;

    modport source (output valid, output out_ch, output status, input ready);
    modport sink   (input valid, input out_ch, input status, output ready);
endinterface

// Register write channel
interface vsc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* src/vigenere_stream_cipher_core.sv */
`timescale 1ns / 1ps

// Channel   Role    Payload               Handshake
// i_in      sink    ch[6:0], first        valid/ready
// o_out     source  out_ch[7:0], status   valid/ready
// i_cfg     sink    index[2:0], data[63:0] valid/ready, always ready
//
// One character per cycle unless the result stalls; input then output register.
// The key position register closes its loop in the transform stage.
// Reset is synchronous, active low, and clears the stage valid flags, the key
// position and the configuration registers to zero.
// A stalled result holds the output register; the input register still takes
// a character when empty or when the output register has room or drains.

module vigenere_stream_cipher_core (
    input  logic   i_clk,
    input  logic   i_rst_n,
    vsc_in_if.sink     i_in,
    vsc_out_if.source  o_out,
    vsc_cfg_if.sink    i_cfg
);
    import vsc_pkg::*;

    t_cfg                  r_cfg;
    logic                  r_in_valid;
    logic [CH_W-1:0]       r_ch;
    logic                  r_first;
    logic [KEY_POS_W-1:0]  r_key_pos;
    logic                  r_out_valid;
    logic [OUT_W-1:0]      r_out_ch;
    t_status               r_status;

    logic                  w_in_fire;
    logic                  w_adv;
    logic                  n_in_valid;
    logic                  n_out_valid;
    t_xform_res            w_res;

    assign w_adv     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_adv;
    assign w_in_fire = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid  = r_out_valid;
    assign o_out.out_ch = r_out_ch;
    assign o_out.status = r_status;

    // Next occupancy of both stages
    always_comb begin
        n_in_valid = r_in_valid;
        if (w_in_fire) begin
            n_in_valid = 1'b1;
        end else if (w_adv) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (w_adv) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    vsc_xform u_xform (
        .i_cfg     (r_cfg),
        .i_ch      (r_ch),
        .i_first   (r_first),
        .i_key_pos (r_key_pos),
        .o_res     (w_res)
    );

    // Hold control state, key position and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_key_pos   <= '0;
            r_cfg       <= '0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (w_adv) begin
                r_key_pos <= w_res.next_pos;
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (t_reg_idx'(i_cfg.index))
                    REG_CASE_MODE: r_cfg.case_mode  <= t_case_mode'(i_cfg.data[1:0]);
                    REG_DIRECTION: r_cfg.direction  <= i_cfg.data[0];
                    REG_KEY_LEN:   r_cfg.key_length <= i_cfg.data[KEY_LEN_W-1:0];
                    REG_KEY_WORD0: r_cfg.key_word[0] <= i_cfg.data;
                    REG_KEY_WORD1: r_cfg.key_word[1] <= i_cfg.data;
                    REG_KEY_WORD2: r_cfg.key_word[2] <= i_cfg.data;
                    REG_KEY_WORD3: r_cfg.key_word[3] <= i_cfg.data;
                    default: ;
                endcase
            end
        end
    end

    // Capture request payload and result payload
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_ch    <= i_in.ch;
            r_first <= i_in.first;
        end
        if (w_adv) begin
            r_out_ch <= w_res.out_ch;
            r_status <= w_res.status;
        end
    end

endmodule

/* src/vsc_xform.sv */
`timescale 1ns / 1ps

module vsc_xform (
    input  vsc_pkg::t_cfg                  i_cfg,
    input  logic [vsc_pkg::CH_W-1:0]       i_ch,
    input  logic                           i_first,
    input  logic [vsc_pkg::KEY_POS_W-1:0]  i_key_pos,
    output vsc_pkg::t_xform_res            o_res
);
    import vsc_pkg::*;

    localparam int REM_STEPS = 11;
    localparam int STEP_W    = 11;

    // Truncated remainder by a modulus input: parallel compares against multiples
    function automatic logic signed [ARITH_W-1:0] srem(
        input logic signed [ARITH_W-1:0] x,
        input logic [CH_W-1:0]           m
    );
        logic [STEP_W-1:0]  mag;
        logic [STEP_W-1:0]  sub;
        logic [STEP_W-1:0]  step;
        logic [ARITH_W-1:0] rem;
        mag  = x[ARITH_W-1] ? STEP_W'(-x) : STEP_W'(x);
        sub  = '0;
        step = '0;
        for (int k = 1; k <= REM_STEPS; k++) begin
            step = STEP_W'(k) * STEP_W'(m);
            if (mag >= step) begin
                sub = step;
            end
        end
        rem = ARITH_W'(mag - sub);
        return x[ARITH_W-1] ? -$signed(rem) : $signed(rem);
    endfunction

    function automatic logic is_up(input logic [OUT_W-1:0] c);
        return (c >= OUT_W'(BASE_UPPER)) && (c <= OUT_W'(BASE_UPPER + ALPHA_LEN - 1));
    endfunction

    function automatic logic is_lo(input logic [OUT_W-1:0] c);
        return (c >= OUT_W'(BASE_LOWER)) && (c <= OUT_W'(BASE_LOWER + ALPHA_LEN - 1));
    endfunction

    logic [KEY_LEN_W-1:0]        w_len;
    logic [KEY_POS_W-1:0]        w_base_pos;
    logic [KEY_POS_W-1:0]        w_pos;
    logic [KEY_LEN_W-1:0]        w_pos_inc;
    logic [OUT_W-1:0]            w_key_raw;
    logic [OUT_W-1:0]            w_text;
    logic signed [ARITH_W-1:0]   w_t;
    logic signed [ARITH_W-1:0]   w_p;
    logic                        w_mixed;
    logic                        w_upper;
    logic                        w_ws;
    logic                        w_text_bad;
    logic                        w_key_bad;
    logic [CH_W-1:0]             w_base;
    logic [CH_W-1:0]             w_fold;
    logic signed [ARITH_W-1:0]   w_sum;
    logic signed [ARITH_W-1:0]   w_rem;
    logic signed [ARITH_W-1:0]   w_res;

    // Clamp key length and pick the current key byte
    assign w_len      = (i_cfg.key_length > KEY_LEN_W'(KEY_CHARS)) ?
                        KEY_LEN_W'(KEY_CHARS) : i_cfg.key_length;
    assign w_base_pos = i_first ? '0 : i_key_pos;
    assign w_pos      = ({1'b0, w_base_pos} >= w_len) ? '0 : w_base_pos;
    assign w_pos_inc  = {1'b0, w_pos} + KEY_LEN_W'(1);
    assign w_key_raw  = i_cfg.key_word[w_pos[KEY_POS_W-1:3]][{w_pos[2:0], 3'b000} +: OUT_W];

    assign w_text  = {1'b0, i_ch};
    assign w_t     = $signed({3'b000, i_ch});
    assign w_p     = $signed({{(ARITH_W-OUT_W){w_key_raw[OUT_W-1]}}, w_key_raw});
    assign w_mixed = i_cfg.case_mode[1];
    assign w_upper = (i_cfg.case_mode == MODE_UPPER);
    assign w_ws    = (i_ch == CH_W'(32)) || ((i_ch >= CH_W'(9)) && (i_ch <= CH_W'(13)));

    // Case checks apply to encryption in the case modes only
    assign w_text_bad = !w_mixed && (i_cfg.direction == DIR_ENCRYPT) &&
                        (w_upper ? is_lo(w_text) : is_up(w_text));
    assign w_key_bad  = !w_mixed && (i_cfg.direction == DIR_ENCRYPT) &&
                        (w_upper ? is_lo(w_key_raw) : is_up(w_key_raw));

    // Shift the character modulo the alphabet
    always_comb begin
        w_base = w_upper ? CH_W'(BASE_UPPER) : CH_W'(BASE_LOWER);
        w_fold = is_up(w_text) ? CH_W'(BASE_UPPER) : CH_W'(BASE_LOWER);
        w_sum  = '0;
        w_rem  = '0;
        w_res  = '0;
        if (!w_mixed) begin
            if (i_cfg.direction == DIR_ENCRYPT) begin
                w_sum = w_t + w_p;
            end else begin
                w_sum = ARITH_W'(ALPHA_LEN) + w_t - w_p;
            end
            w_rem = srem(srem(w_sum, w_base), CH_W'(ALPHA_LEN));
            w_res = w_rem + $signed({3'b000, w_base});
        end else begin
            if (i_cfg.direction == DIR_ENCRYPT) begin
                w_sum = w_t - $signed({3'b000, w_fold}) + w_p;
            end else begin
                w_sum = w_t - $signed({3'b000, w_fold}) - w_p;
            end
            w_rem = srem(w_sum, CH_W'(ALPHA_LEN));
            w_res = w_rem + $signed({3'b000, w_fold});
            if ((i_cfg.direction != DIR_ENCRYPT) && w_rem[ARITH_W-1]) begin
                w_res = w_res + ARITH_W'(ALPHA_LEN);
            end
        end
    end

    // Select status, output and next key position
    always_comb begin
        o_res.out_ch   = w_text;
        o_res.status   = ST_OK;
        o_res.next_pos = w_base_pos;
        if (w_len == '0) begin
            o_res.status = ST_NO_KEY;
        end else if (w_ws) begin
            o_res.status = ST_OK;
        end else if (w_text_bad) begin
            o_res.status = ST_TEXT_CASE;
        end else if (w_key_bad) begin
            o_res.status = ST_KEY_CASE;
        end else begin
            o_res.out_ch   = w_res[OUT_W-1:0];
            o_res.next_pos = (w_pos_inc >= w_len) ? '0 : w_pos_inc[KEY_POS_W-1:0];
        end
    end

endmodule

/* src/vsc_checker.sv */
`timescale 1ns / 1ps

module vsc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_ch,
    input logic [1:0] i_status
);
    import vsc_pkg::*;

    // A pending result stays offered until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result request dropped while stalled");

    // Input stalls only when both stages are full and the result is stalled
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input stalled with room in the pipeline");

    // Flagged results carry a clear top bit, as a 7-bit input character would
    a_flag_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status != ST_OK) |-> !i_out_ch[7])
        else $error("flagged result altered the character");

    // Nothing is offered right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind vigenere_stream_cipher_core vsc_checker u_vsc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_ch    (o_out.out_ch),
    .i_status    (o_out.status)
);

/* tb/vigenere_stream_cipher_core_test.sv */
`timescale 1ns / 1ps

module vigenere_stream_cipher_core_test;
    import vsc_pkg::*;

    localparam logic       DIR_DECRYPT    = 1'b1;
    localparam logic [2:0] REG_UNUSED     = 3'd7;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         HOLD_CYCLES    = 300;
    localparam int         RANDOM_ITEMS   = 1825;
    localparam int         MAX_REPORTS    = 40;

    typedef struct packed {
        logic [OUT_W-1:0] out_ch;
        t_status          status;
    } t_cipher_res;

    logic i_clk;
    logic i_rst_n;

    vsc_in_if  char_if ();
    vsc_out_if res_if ();
    vsc_cfg_if reg_if ();

    vigenere_stream_cipher_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (char_if),
        .o_out   (res_if),
        .i_cfg   (reg_if)
    );

    // Shadow copy of the cipher registers and key position
    logic [1:0]        cfg_mode;
    logic              cfg_dir;
    logic [5:0]        cfg_len;
    logic [WORD_W-1:0] cfg_key [KEY_WORDS];
    logic [4:0]        key_idx;

    t_cipher_res cipher_q [$];
    int          mismatch_count = 0;
    int          result_count = 0;
    int          tx_idle_max = 0;
    int          rx_idle_max = 0;
    int          rx_hold_cycles = 0;
    int          quiet_cycles = 0;

    // Free-running clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic logic is_space(input int c);
        return c == 32 || (c >= 9 && c <= 13);
    endfunction

    function automatic logic is_upper(input int c);
        return c >= BASE_UPPER && c <= BASE_UPPER + ALPHA_LEN - 1;
    endfunction

    function automatic logic is_lower(input int c);
        return c >= BASE_LOWER && c <= BASE_LOWER + ALPHA_LEN - 1;
    endfunction

    // Work out the cipher result for one character and advance the key position
    task automatic cipher_step(input logic [6:0] ch, input logic first,
                               output t_cipher_res res);
        int         t, p, r, f, m, n, pos;
        logic [7:0] kb;
        logic       mixed, upper;
        t     = int'(ch);
        mixed = cfg_mode[1];
        upper = (cfg_mode == MODE_UPPER);
        if (first) begin
            key_idx = '0;
        end
        n = (cfg_len > KEY_CHARS) ? KEY_CHARS : int'(cfg_len);
        res.out_ch = {1'b0, ch};
        res.status = ST_OK;
        if (n == 0) begin
            res.status = ST_NO_KEY;
            return;
        end
        if (is_space(t)) begin
            return;
        end
        // Stale position after the key shrinks falls back to the first key character
        pos = int'(key_idx);
        if (pos >= n) begin
            pos = 0;
        end
        kb = cfg_key[pos >> 3][8 * (pos & 7) +: 8];
        p  = (kb >= 8'd128) ? int'(kb) - 256 : int'(kb);
        // Flag wrong case in a case-mode encrypt, hold the position
        if (!mixed && cfg_dir == DIR_ENCRYPT) begin
            if (upper ? is_lower(t) : is_upper(t)) begin
                res.status = ST_TEXT_CASE;
                return;
            end
            if (upper ? is_lower(p) : is_upper(p)) begin
                res.status = ST_KEY_CASE;
                return;
            end
        end
        if (!mixed) begin
            f = upper ? BASE_UPPER : BASE_LOWER;
            if (cfg_dir == DIR_ENCRYPT) begin
                r = ((t + p) % f) % ALPHA_LEN + f;
            end else begin
                r = ((ALPHA_LEN + t - p) % f) % ALPHA_LEN + f;
            end
        end else begin
            f = is_upper(t) ? BASE_UPPER : BASE_LOWER;
            if (cfg_dir == DIR_ENCRYPT) begin
                r = (t - f + p) % ALPHA_LEN + f;
            end else begin
                m = (t - f - p) % ALPHA_LEN;
                r = m + (m < 0 ? ALPHA_LEN : 0) + f;
            end
        end
        res.out_ch = r[7:0];
        pos++;
        key_idx = (pos >= n) ? 5'd0 : pos[4:0];
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("mismatch at result %0d: %s got %0d expected %0d",
                     result_count, what, got, want);
        end
    endtask

    // Track register writes, predict accepted characters, check accepted results
    always @(posedge i_clk) begin : scoreboard
        t_cipher_res want;
        if (reg_if.valid && reg_if.ready) begin
            case (reg_if.index)
                REG_CASE_MODE: cfg_mode   = reg_if.data[1:0];
                REG_DIRECTION: cfg_dir    = reg_if.data[0];
                REG_KEY_LEN:   cfg_len    = reg_if.data[5:0];
                REG_KEY_WORD0: cfg_key[0] = reg_if.data;
                REG_KEY_WORD1: cfg_key[1] = reg_if.data;
                REG_KEY_WORD2: cfg_key[2] = reg_if.data;
                REG_KEY_WORD3: cfg_key[3] = reg_if.data;
                default: ;
            endcase
        end
        if (char_if.valid && char_if.ready) begin
            cipher_step(char_if.ch, char_if.first, want);
            cipher_q.push_back(want);
        end
        if (res_if.valid && res_if.ready) begin
            if (cipher_q.size() == 0) begin
                report_mismatch("unexpected result, out_ch", int'(res_if.out_ch), -1);
            end else begin
                want = cipher_q.pop_front();
                if (res_if.out_ch !== want.out_ch) begin
                    report_mismatch("out_ch", int'(res_if.out_ch), int'(want.out_ch));
                end
                if (res_if.status !== want.status) begin
                    report_mismatch("status", int'(res_if.status), int'(want.status));
                end
            end
            result_count++;
        end
    end

    // End the run when no request moves for too long
    always @(posedge i_clk) begin
        if ((char_if.valid && char_if.ready) || (res_if.valid && res_if.ready) ||
            (reg_if.valid && reg_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no request accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("[vigenere_stream_cipher_core] ERROR");
            $finish;
        end
    end

    // Result sink: random stall per result, or one long hold when asked
    initial begin : result_sink
        int gap;
        res_if.ready = 1'b0;
        forever begin
            if (rx_hold_cycles > 0) begin
                gap = rx_hold_cycles;
                rx_hold_cycles = 0;
            end else begin
                gap = (rx_idle_max == 0) ? 0 : $urandom_range(rx_idle_max, 0);
            end
            repeat (gap) begin
                @(negedge i_clk);
                res_if.ready <= 1'b0;
            end
            @(negedge i_clk);
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (!res_if.valid);
        end
    end

    // Offer one character request after a random gap, return once accepted
    task automatic send_char(input logic [6:0] ch, input logic first);
        int gap;
        gap = (tx_idle_max == 0) ? 0 : $urandom_range(tx_idle_max, 0);
        repeat (gap) begin
            @(negedge i_clk);
            char_if.valid <= 1'b0;
        end
        @(negedge i_clk);
        char_if.valid <= 1'b1;
        char_if.ch    <= ch;
        char_if.first <= first;
        do @(posedge i_clk); while (!char_if.ready);
    endtask

    // Drop the character request and wait until every result is back
    task automatic drain_results();
        @(negedge i_clk);
        char_if.valid <= 1'b0;
        while (cipher_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
        @(negedge i_clk);
        reg_if.valid <= 1'b1;
        reg_if.index <= idx;
        reg_if.data  <= data;
        do @(posedge i_clk); while (!reg_if.ready);
        @(negedge i_clk);
        reg_if.valid <= 1'b0;
    endtask

    task automatic load_cipher(input logic [1:0] mode, input logic dir, input logic [5:0] len,
                               input logic [63:0] w0, input logic [63:0] w1,
                               input logic [63:0] w2, input logic [63:0] w3);
        write_reg(REG_CASE_MODE, 64'(mode));
        write_reg(REG_DIRECTION, 64'(dir));
        write_reg(REG_KEY_LEN, 64'(len));
        write_reg(REG_KEY_WORD0, w0);
        write_reg(REG_KEY_WORD1, w1);
        write_reg(REG_KEY_WORD2, w2);
        write_reg(REG_KEY_WORD3, w3);
    endtask

    function automatic logic [7:0] rand_letter(input logic lower);
        return (lower ? 8'd97 : 8'd65) + 8'($urandom_range(ALPHA_LEN - 1, 0));
    endfunction

    // Mixed modes pick either case; case modes follow their alphabet
    function automatic logic pick_lower(input logic [1:0] mode);
        if (mode[1]) begin
            return 1'($urandom_range(1, 0));
        end
        return mode == MODE_LOWER;
    endfunction

    function automatic logic [6:0] rand_text_char(input logic [1:0] mode);
        int   sel, w;
        logic lower;
        sel   = $urandom_range(99, 0);
        w     = $urandom_range(6, 0);
        lower = pick_lower(mode);
        if (sel < 70) begin
            return 7'(rand_letter(lower));
        end
        if (sel < 80) begin
            return (w == 6) ? 7'd32 : 7'd9 + w[6:0];
        end
        if (sel < 88) begin
            return 7'(rand_letter(!lower));
        end
        return 7'($urandom_range(127, 0));
    endfunction

    function automatic logic [7:0] rand_key_byte(input logic [1:0] mode);
        int   sel;
        logic lower;
        sel   = $urandom_range(99, 0);
        lower = pick_lower(mode);
        if (sel < 75) begin
            return rand_letter(lower);
        end
        if (sel < 85) begin
            return rand_letter(!lower);
        end
        return 8'($urandom_range(255, 0));
    endfunction

    // Registers at reset: no key, so every character is flagged
    task automatic test_no_key();
        send_char(7'd32, 1'b1);
        send_char(7'("A"), 1'b0);
        send_char(7'h00, 1'b0);
        send_char(7'h7F, 1'b1);
    endtask

    // A write to an index past the last register must change nothing
    task automatic test_unused_index();
        drain_results();
        write_reg(REG_UNUSED, '1);
        send_char(7'("Q"), 1'b1);
    endtask

    // Upper-case encrypt: wrong text case, wrong key case, whitespace, negative key byte
    task automatic test_upper_encrypt();
        drain_results();
        // key "K", "Z", 0xF0, "q"
        load_cipher(MODE_UPPER, DIR_ENCRYPT, 6'd4, {32'd0, "q", 8'hF0, "Z", "K"}, '0, '0, '0);
        send_char(7'("H"), 1'b1);
        send_char(7'("i"), 1'b0);
        send_char(7'("Z"), 1'b0);
        send_char(7'd10, 1'b0);
        send_char(7'h00, 1'b0);
        send_char(7'("A"), 1'b0);
    endtask

    // Lower-case decrypt ignores case, then lower-case encrypt flags it
    task automatic test_lower_modes();
        drain_results();
        write_reg(REG_CASE_MODE, 64'(MODE_LOWER));
        write_reg(REG_DIRECTION, 64'(DIR_DECRYPT));
        send_char(7'("a"), 1'b1);
        send_char(7'("Z"), 1'b0);
        send_char(7'h7F, 1'b0);
        send_char(7'd32, 1'b0);
        drain_results();
        write_reg(REG_DIRECTION, 64'(DIR_ENCRYPT));
        send_char(7'("b"), 1'b1);
        send_char(7'("C"), 1'b0);
    endtask

    // Mixed case both ways, and the spare mode code acting as mixed
    task automatic test_mixed_modes();
        drain_results();
        load_cipher(MODE_MIXED, DIR_ENCRYPT, 6'd2, {48'd0, 8'h80, "b"}, '0, '0, '0);
        send_char(7'("A"), 1'b1);
        send_char(7'("z"), 1'b0);
        send_char(7'("5"), 1'b0);
        drain_results();
        write_reg(REG_DIRECTION, 64'(DIR_DECRYPT));
        send_char(7'("A"), 1'b1);
        send_char(7'("m"), 1'b0);
        drain_results();
        write_reg(REG_CASE_MODE, 64'(MODE_MIXED_ALT));
        send_char(7'("r"), 1'b0);
    endtask

    // Length above the key store, then a shrink that leaves the position stale
    task automatic test_long_key_and_stale_pos();
        drain_results();
        load_cipher(MODE_UPPER, DIR_ENCRYPT, 6'd63, '1, '1, '1, '1);
        send_char(7'("B"), 1'b1);
        send_char(7'("C"), 1'b0);
        drain_results();
        write_reg(REG_KEY_LEN, 64'd1);
        send_char(7'("D"), 1'b0);
    endtask

    // Hold the result side long enough for the input to stall
    task automatic test_backpressure();
        drain_results();
        load_cipher(MODE_UPPER, DIR_ENCRYPT, 6'd5, {24'd0, "VWXYZ"}, '0, '0, '0);
        tx_idle_max    = 0;
        rx_idle_max    = 0;
        rx_hold_cycles = HOLD_CYCLES;
        for (int i = 0; i < 30; i++) begin
            send_char(7'(rand_letter(1'b0)), i == 0);
        end
    endtask

    // Random settings per phase, each followed by a message of random content
    task automatic test_random_traffic(input int item_target);
        int          sent, sel, msg_len;
        logic [1:0]  mode;
        logic        dir;
        logic [5:0]  len;
        logic [63:0] words [KEY_WORDS];
        sent = 0;
        while (sent < item_target) begin
            drain_results();
            sel = $urandom_range(99, 0);
            if (sel < 5) begin
                len = 6'd0;
            end else if (sel < 15) begin
                len = 6'd32;
            end else if (sel < 25) begin
                len = 6'd1;
            end else if (sel < 32) begin
                len = 6'($urandom_range(63, 33));
            end else begin
                len = 6'($urandom_range(31, 2));
            end
            if ($urandom_range(9, 0) == 0) begin
                // Shrink or grow the key only, keeping the old position
                mode = cfg_mode;
                write_reg(REG_KEY_LEN, 64'(len));
            end else begin
                mode = 2'($urandom_range(3, 0));
                dir  = 1'($urandom_range(1, 0));
                sel  = $urandom_range(19, 0);
                for (int w = 0; w < KEY_WORDS; w++) begin
                    for (int b = 0; b < 8; b++) begin
                        words[w][8 * b +: 8] = rand_key_byte(mode);
                    end
                    if (sel == 0) begin
                        words[w] = '0;
                    end else if (sel == 1) begin
                        words[w] = '1;
                    end
                end
                load_cipher(mode, dir, len, words[0], words[1], words[2], words[3]);
            end
            case ($urandom_range(3, 0))
                0: begin tx_idle_max = 0;  rx_idle_max = 0;  end
                1: begin tx_idle_max = 18; rx_idle_max = 0;  end
                2: begin tx_idle_max = 0;  rx_idle_max = 18; end
                default: begin tx_idle_max = 18; rx_idle_max = 18; end
            endcase
            msg_len = $urandom_range(60, 1);
            for (int i = 0; i < msg_len; i++) begin
                send_char(rand_text_char(mode),
                          (i == 0) ? ($urandom_range(9, 0) != 0) : ($urandom_range(29, 0) == 0));
            end
            sent += msg_len;
        end
    endtask

    initial begin : run
        char_if.valid = 1'b0;
        char_if.ch    = '0;
        char_if.first = 1'b0;
        reg_if.valid  = 1'b0;
        reg_if.index  = '0;
        reg_if.data   = '0;
        i_rst_n       = 1'b0;
        cfg_mode      = MODE_UPPER;
        cfg_dir       = DIR_ENCRYPT;
        cfg_len       = '0;
        cfg_key       = '{default: '0};
        key_idx       = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_no_key();
        test_unused_index();
        test_upper_encrypt();
        test_lower_modes();
        test_mixed_modes();
        test_long_key_and_stale_pos();
        test_backpressure();
        test_random_traffic(RANDOM_ITEMS);

        // Let the pipeline settle, then flag anything still owed
        drain_results();
        repeat (4) @(posedge i_clk);
        while (cipher_q.size() != 0) begin
            report_mismatch("missing result, out_ch", -1, int'(cipher_q[0].out_ch));
            void'(cipher_q.pop_front());
        end
        if (mismatch_count == 0) begin
            $display("[vigenere_stream_cipher_core] OK");
        end else begin
            $display("[vigenere_stream_cipher_core] ERROR");
        end
        $finish;
    end

endmodule

/* filelist.f */
src/vsc_pkg.sv
src/vsc_if.sv
src/vsc_xform.sv
src/vigenere_stream_cipher_core.sv
src/vsc_checker.sv
tb/vigenere_stream_cipher_core_test.sv
